### sv/pcn_pkg.sv
package pcn_pkg;

  localparam int MaxPoints = 64;
  localparam int FracBits  = 12;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = AddrW + 1;
  localparam int CoordW    = 24;
  localparam int SumW      = 30;
  localparam int SqW       = 50;
  localparam int RadW      = 25;
  localparam int OffW      = 25;
  localparam int DivW      = OffW + FracBits;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic                     final_point;
  } pcn_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] norm_x;
    logic signed [CoordW-1:0] norm_y;
    logic signed [CoordW-1:0] norm_z;
    logic                     degenerate;
    logic                     overflowed;
    logic                     end_of_run;
  } pcn_out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CENT,
    OP_DIST,
    OP_SCALE,
    OP_EMIT,
    OP_CLEAR
  } pcn_op_e;

  typedef struct packed {
    pcn_op_e          op;
    logic             start;  // begin a multi-cycle operation
    logic [AddrW-1:0] addr;   // memory read address
    logic [1:0]       axis;   // axis selection for centroid / scale
    logic             last;   // end_of_run for the emitted item
  } pcn_cmd_t;

  typedef struct packed {
    logic             done;   // multi-cycle operation finished
    logic [CntW-1:0]  count;
    logic             degen;
  } pcn_sts_t;

endpackage

### sv/pcn_ctrl.sv
module pcn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              final_i,
  input  pcn_pkg::pcn_sts_t sts_i,
  output logic              busy_o,
  output pcn_pkg::pcn_cmd_t cmd_o
);
  import pcn_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CENT_GO,
    S_CENT_WAIT,
    S_DIST_GO,
    S_DIST_WAIT,
    S_SCL_GO,
    S_SCL_WAIT,
    S_EMIT,
    S_CLEAR
  } state_e;

  state_e           state_q;
  logic [1:0]       axis_q;
  logic [AddrW-1:0] idx_q, idx_d;

  logic last_pt;
  assign last_pt = ({1'b0, idx_q} == sts_i.count - CntW'(1));

  // Advance the point index; the memory reads ahead with the next index.
  always_comb begin
    idx_d = idx_q;
    case (state_q)
      S_CENT_WAIT: begin
        if (sts_i.done && axis_q == 2'd2) idx_d = '0;
      end
      S_DIST_WAIT: begin
        if (sts_i.done) idx_d = last_pt ? '0 : idx_q + AddrW'(1);
      end
      S_EMIT: begin
        if (!last_pt) idx_d = idx_q + AddrW'(1);
      end
      S_CLEAR: idx_d = '0;
      default: ;
    endcase
  end

  // Drive datapath commands from the state.
  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = OP_IDLE;
    cmd_o.addr  = idx_d;
    cmd_o.axis  = axis_q;
    cmd_o.last  = last_pt;
    busy_o      = (state_q != S_LOAD);
    case (state_q)
      S_LOAD: begin
        cmd_o.op = start_i ? OP_LOAD : OP_IDLE;
      end
      S_CENT_GO: begin
        cmd_o.op = OP_CENT;
        cmd_o.start = 1'b1;
      end
      S_CENT_WAIT: cmd_o.op = OP_CENT;
      S_DIST_GO: begin
        cmd_o.op = OP_DIST;
        cmd_o.start = 1'b1;
      end
      S_DIST_WAIT: cmd_o.op = OP_DIST;
      S_SCL_GO: begin
        cmd_o.op = OP_SCALE;
        cmd_o.start = 1'b1;
      end
      S_SCL_WAIT: cmd_o.op = OP_SCALE;
      S_EMIT:     cmd_o.op = OP_EMIT;
      S_CLEAR:    cmd_o.op = OP_CLEAR;
      default:    cmd_o.op = OP_IDLE;
    endcase
  end

  // Sequence centroid, distance, scaling and emit passes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      axis_q  <= '0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      case (state_q)
        S_LOAD: begin
          if (start_i && final_i) begin
            state_q <= S_CENT_GO;
            axis_q  <= '0;
          end
        end
        S_CENT_GO: state_q <= S_CENT_WAIT;
        S_CENT_WAIT: begin
          if (sts_i.done) begin
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              state_q <= S_DIST_GO;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_CENT_GO;
            end
          end
        end
        S_DIST_GO: state_q <= S_DIST_WAIT;
        S_DIST_WAIT: begin
          if (sts_i.done) begin
            if (last_pt) begin
              state_q <= S_SCL_GO;
            end else begin
              state_q <= S_DIST_GO;
            end
          end
        end
        S_SCL_GO: state_q <= S_SCL_WAIT;
        S_SCL_WAIT: begin
          if (sts_i.done || sts_i.degen) begin
            if (axis_q == 2'd2 || sts_i.degen) begin
              axis_q  <= '0;
              state_q <= S_EMIT;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_SCL_GO;
            end
          end
        end
        S_EMIT: begin
          if (last_pt) begin
            state_q <= S_CLEAR;
          end else begin
            state_q <= S_SCL_GO;
          end
        end
        S_CLEAR: begin
          state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |=> !busy_o)
    else $error("block still busy after clear");
  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && final_i && !busy_o |=> busy_o)
    else $error("final item did not start processing");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> {1'b0, idx_q} < sts_i.count)
    else $error("point index beyond count");
`endif

endmodule

### sv/pcn_div.sv
module pcn_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [pcn_pkg::DivW-1:0] num_i,
  input  logic [pcn_pkg::SumW-1:0]      den_i,
  output logic                          done_o,
  output logic signed [pcn_pkg::DivW-1:0] quo_o
);
  import pcn_pkg::*;

  localparam int StepW = $clog2(DivW + 1);

  logic [DivW-1:0]  rem_q, quo_q;
  logic [SumW-1:0]  den_q;
  logic             neg_q, run_q;
  logic [StepW-1:0] step_q;
  logic [DivW:0]    trial;
  logic [DivW-1:0]  rem_sh;

  // Shift in one dividend bit, subtract when it fits.
  assign rem_sh = {rem_q[DivW-2:0], quo_q[DivW-1]};
  assign trial  = {1'b0, rem_sh} - {{(DivW + 1 - SumW){1'b0}}, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= StepW'(DivW);
      end else if (run_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DivW-1];
      quo_q <= num_i[DivW-1] ? DivW'(-num_i) : DivW'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      if (!trial[DivW]) begin
        rem_q <= trial[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### sv/pcn_dpath.sv
module pcn_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcn_pkg::pcn_in_t  in_i,
  input  pcn_pkg::pcn_cmd_t cmd_i,
  output pcn_pkg::pcn_sts_t sts_o,
  output logic              strobe_o,
  output pcn_pkg::pcn_out_t result_o
);
  import pcn_pkg::*;

  localparam int SqrtStepW = $clog2(RadW + 1);

  logic [3*CoordW-1:0] mem_q [MaxPoints];
  logic [3*CoordW-1:0] rd_q;
  logic signed [SumW-1:0]   sum_q [3];
  logic signed [CoordW-1:0] cent_q [3];
  logic signed [CoordW-1:0] res_q [3];
  logic [CntW-1:0]          cnt_q;
  logic                     drop_q;
  logic [RadW-1:0]          rad_q;

  // Division unit, shared by centroid and scaling.
  logic                   div_start, div_done;
  logic signed [DivW-1:0] div_num, div_q;
  logic [SumW-1:0]        div_den;

  logic signed [CoordW-1:0] rd_c [3];
  logic signed [OffW-1:0]   off  [3];
  assign rd_c[0] = rd_q[3*CoordW-1:2*CoordW];
  assign rd_c[1] = rd_q[2*CoordW-1:CoordW];
  assign rd_c[2] = rd_q[CoordW-1:0];
  for (genvar a = 0; a < 3; a++) begin : g_off
    assign off[a] = OffW'(rd_c[a]) - OffW'(cent_q[a]);
  end

  always_comb begin
    div_start = cmd_i.start && (cmd_i.op == OP_CENT || cmd_i.op == OP_SCALE);
    if (cmd_i.op == OP_CENT) begin
      div_num = DivW'(sum_q[cmd_i.axis]);
      div_den = SumW'(cnt_q);
    end else begin
      div_num = DivW'(off[cmd_i.axis]) <<< FracBits;
      div_den = SumW'(rad_q);
    end
  end

  pcn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // Squared distance, one axis product a cycle, then bit-pair square root.
  logic [1:0]           sq_ph_q;
  logic                 sq_run_q, rt_run_q, rt_done_q;
  logic [SqW-1:0]       acc_q, rem_q;
  logic [RadW-1:0]      root_q;
  logic [SqrtStepW-1:0] rt_step_q;
  logic [OffW-1:0]      mag;
  logic [SqW-1:0]       prod_q;
  logic                 prod_v_q;
  logic [RadW+1:0]      rt_trial;
  logic [RadW+1:0]      rt_rem_sh;

  assign mag = off[sq_ph_q][OffW-1] ? OffW'(-off[sq_ph_q]) : OffW'(off[sq_ph_q]);
  assign rt_rem_sh = {rem_q[RadW-1:0], acc_q[SqW-1:SqW-2]};
  assign rt_trial  = rt_rem_sh - {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_run_q  <= 1'b0;
      rt_run_q  <= 1'b0;
      rt_done_q <= 1'b0;
      prod_v_q  <= 1'b0;
      sq_ph_q   <= '0;
      rt_step_q <= '0;
    end else begin
      rt_done_q <= 1'b0;
      prod_v_q  <= sq_run_q;
      if (cmd_i.op == OP_DIST && cmd_i.start) begin
        sq_run_q <= 1'b1;
        sq_ph_q  <= '0;
      end else if (sq_run_q) begin
        sq_ph_q <= sq_ph_q + 2'd1;
        if (sq_ph_q == 2'd2) sq_run_q <= 1'b0;
      end
      if (prod_v_q && !sq_run_q) begin
        rt_run_q  <= 1'b1;
        rt_step_q <= SqrtStepW'(RadW);
      end else if (rt_run_q) begin
        rt_step_q <= rt_step_q - SqrtStepW'(1);
        if (rt_step_q == SqrtStepW'(1)) begin
          rt_run_q  <= 1'b0;
          rt_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= SqW'(mag) * SqW'(mag);
    if (cmd_i.op == OP_DIST && cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (prod_v_q && !sq_run_q) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (rt_run_q) begin
      acc_q <= {acc_q[SqW-3:0], 2'b00};
      if (!rt_trial[RadW+1]) begin
        rem_q  <= SqW'(rt_trial);
        root_q <= {root_q[RadW-2:0], 1'b1};
      end else begin
        rem_q  <= SqW'(rt_rem_sh);
        root_q <= {root_q[RadW-2:0], 1'b0};
      end
    end
  end

  // Point store and running sums.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && cnt_q < CntW'(MaxPoints)) begin
      mem_q[cnt_q[AddrW-1:0]] <= {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    end
    rd_q <= mem_q[cmd_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) sum_q[a] <= '0;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      rad_q    <= '0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      case (cmd_i.op)
        OP_LOAD: begin
          if (cnt_q < CntW'(MaxPoints)) begin
            sum_q[0] <= sum_q[0] + SumW'(in_i.coord_x);
            sum_q[1] <= sum_q[1] + SumW'(in_i.coord_y);
            sum_q[2] <= sum_q[2] + SumW'(in_i.coord_z);
            cnt_q    <= cnt_q + CntW'(1);
          end else begin
            drop_q <= 1'b1;
          end
        end
        OP_DIST: begin
          if (rt_done_q && root_q > rad_q) rad_q <= root_q;
        end
        OP_EMIT: strobe_o <= 1'b1;
        OP_CLEAR: begin
          for (int a = 0; a < 3; a++) sum_q[a] <= '0;
          cnt_q  <= '0;
          drop_q <= 1'b0;
          rad_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Capture quotients and the emitted item.
  always_ff @(posedge clk_i) begin
    if (div_done && cmd_i.op == OP_CENT) cent_q[cmd_i.axis] <= CoordW'(div_q);
    if (div_done && cmd_i.op == OP_SCALE) res_q[cmd_i.axis] <= CoordW'(div_q);
    if (cmd_i.op == OP_EMIT) begin
      result_o.degenerate <= (rad_q == '0);
      result_o.overflowed <= drop_q;
      result_o.end_of_run <= cmd_i.last;
      result_o.norm_x <= (rad_q == '0) ? rd_c[0] : res_q[0];
      result_o.norm_y <= (rad_q == '0) ? rd_c[1] : res_q[1];
      result_o.norm_z <= (rad_q == '0) ? rd_c[2] : res_q[2];
    end
  end

  assign sts_o.done  = (cmd_i.op == OP_DIST) ? rt_done_q : div_done;
  assign sts_o.count = cnt_q;
  assign sts_o.degen = (rad_q == '0) && (cmd_i.op == OP_SCALE) && !cmd_i.start;

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPoints))
    else $error("point count beyond capacity");
  a_rad_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_DIST |=> rad_q >= $past(rad_q))
    else $error("radius decreased during distance pass");
  a_emit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("back to back emits");
`endif

endmodule

### sv/point_cloud_unit_sphere_normalize_top.sv
// Point cloud unit-sphere normalization.
// Input: raise start with a point on in_i; it is taken when busy is low.
// Non-final points raise no result; up to 64 points are stored, further ones
// are dropped and flag overflowed on the output.
// A point with final_point set is stored and then starts processing:
// busy stays high while the centroid (three 37-step serial divides), the
// per-point distance (3 square products plus a 25-step square root) and
// the per-point scaling (three 37-step serial divides) run. One shared
// bit-serial divider and one root unit serve all of these passes.
// Each result appears for one cycle with strobe_o high; end_of_run marks the
// last. The receiver cannot stall. When the radius is zero, points leave
// unchanged with degenerate set. Reset clears counters, sums and flags;
// stored points need no clearing.
module point_cloud_unit_sphere_normalize_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pcn_pkg::pcn_in_t  in_i,
  output logic              strobe_o,
  output pcn_pkg::pcn_out_t result_o
);
  import pcn_pkg::*;

  pcn_cmd_t cmd;
  pcn_sts_t sts;

  pcn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .final_i (in_i.final_point),
    .sts_i   (sts),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  pcn_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule
